### rtl/core/sensor_scale_and_moving_average_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sensor scale and moving average block
// Each macro builds one labeled concurrent assertion on a clock and reset.
// ---------------------------------------------------------------------------
`ifndef SENSOR_SCALE_AND_MOVING_AVERAGE_TOP_ASSERT_SVH
`define SENSOR_SCALE_AND_MOVING_AVERAGE_TOP_ASSERT_SVH

// same-cycle implication
`define SMAV_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("smav: same-cycle check failed");

// next-cycle implication
`define SMAV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smav: next-cycle check failed");

// invariant
`define SMAV_ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("smav: invariant failed");

`endif

### rtl/core/smav_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smav_pkg
// Shared widths, register indexes, payload and control types.
// ---------------------------------------------------------------------------
package smav_pkg;

   localparam int MV_W                  = 12;
   localparam int VAL_W                 = 16;
   localparam int NUM_W                 = MV_W + VAL_W;
   localparam int CSR_IDX_W             = 2;
   localparam int CSR_DATA_W            = 16;
   localparam int WINDOW_LENGTH_DEFAULT = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_MV     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_MV    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE = 2'd2;

   localparam logic [MV_W-1:0]  LOW_MV_RESET     = 12'd0;
   localparam logic [MV_W-1:0]  HIGH_MV_RESET    = 12'd3300;
   localparam logic [VAL_W-1:0] FULL_SCALE_RESET = 16'd4095;

   typedef struct packed {
      logic [MV_W-1:0] sample_millivolts;
   } req_payload_type;

   typedef struct packed {
      logic [VAL_W-1:0] smoothed_value;
      logic [VAL_W-1:0] scaled_sample;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic scale_start;
      logic scale_load_div;
      logic fill_write;
      logic update;
      logic mean;
      logic load_out;
      logic out_direct;
   } cmd_type;

   typedef struct packed {
      logic clamp;
      logic div_busy;
      logic primed;
      logic fill_last;
   } status_type;

endpackage

### rtl/core/smav_stream_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smav_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ---------------------------------------------------------------------------
interface smav_stream_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

### rtl/core/smav_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smav_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module smav_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/smav_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smav_div
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// VAL_W bits, so the upper dividend bits are below the divisor.
// ---------------------------------------------------------------------------
module smav_div import smav_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [MV_W-1:0]  divisor,
   output logic             busy,
   output logic [VAL_W-1:0] quotient
);

   localparam int CNT_W = $clog2(VAL_W + 1);

   logic [MV_W-1:0]  rem_ff, rem_in;
   logic [VAL_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [MV_W:0]    trial;
   logic [MV_W:0]    trial_sub;
   logic             fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[VAL_W-1]};
      trial_sub = trial - {1'b0, divisor};
      fits      = trial >= {1'b0, divisor};
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      if (start) begin
         rem_in = dividend[NUM_W-1:VAL_W];
         quo_in = dividend[VAL_W-1:0];
         cnt_in = CNT_W'(VAL_W);
      end else if (cnt_ff != '0) begin
         rem_in = fits ? trial_sub[MV_W-1:0] : trial[MV_W-1:0];
         quo_in = {quo_ff[VAL_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;

endmodule

### rtl/core/smav_dpath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smav_dpath
// Configuration registers, clamp and rescale, window ring, running sum and
// mean by reciprocal multiply.
// ---------------------------------------------------------------------------
module smav_dpath import smav_pkg::*; #(
   parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_payload_type       req_payload,
   output rsp_payload_type       rsp_payload,
   input  cmd_type               cmd,
   output status_type            status
);

   localparam int PTR_W   = $clog2(WINDOW_LENGTH);
   localparam int SUM_W   = VAL_W + PTR_W;
   localparam int SHIFT   = SUM_W + PTR_W;
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam longint unsigned RECIP_FULL = (64'd1 << SHIFT) / WINDOW_LENGTH + 64'd1;
   localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_FULL);
   localparam logic [PTR_W-1:0]   LAST_POS = PTR_W'(WINDOW_LENGTH - 1);

   logic [MV_W-1:0]   low_ff, low_in;
   logic [MV_W-1:0]   high_ff, high_in;
   logic [VAL_W-1:0]  fs_ff, fs_in;
   logic [MV_W-1:0]   sample_ff, sample_in;
   logic [VAL_W-1:0]  scaled_ff, scaled_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [PTR_W-1:0]  pos_ff, pos_in;
   logic [PTR_W-1:0]  fill_cnt_ff, fill_cnt_in;
   logic              primed_ff, primed_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   rsp_payload_type   out_ff, out_in;

   logic              clamp_low;
   logic              clamp_high;
   logic [VAL_W-1:0]  clamp_value;
   logic [MV_W-1:0]   diff;
   logic [MV_W-1:0]   span;
   logic [NUM_W-1:0]  num;
   logic              div_busy;
   logic [VAL_W-1:0]  quotient;
   logic              ram_we;
   logic [PTR_W-1:0]  ram_waddr;
   logic [VAL_W-1:0]  oldest;
   logic              fill_last;
   logic [VAL_W-1:0]  mean_value;

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      fs_in   = fs_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LOW_MV:     low_in  = csr_wdata[MV_W-1:0];
            CSR_HIGH_MV:    high_in = csr_wdata[MV_W-1:0];
            CSR_FULL_SCALE: fs_in   = csr_wdata[VAL_W-1:0];
            default:        low_in  = low_ff;
         endcase
      end
   end

   always_comb begin
      clamp_low   = sample_ff <= low_ff;
      clamp_high  = sample_ff >= high_ff;
      clamp_value = clamp_low ? '0 : fs_ff;
      diff        = sample_ff - low_ff;
      span        = high_ff - low_ff;
      num         = {{VAL_W{1'b0}}, diff} * {{MV_W{1'b0}}, fs_ff};
   end

   smav_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.scale_start & ~(clamp_low | clamp_high)),
      .dividend (num),
      .divisor  (span),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign fill_last = fill_cnt_ff == LAST_POS;
   assign ram_we    = cmd.fill_write | cmd.update;
   assign ram_waddr = cmd.fill_write ? fill_cnt_ff : pos_ff;

   smav_ram #(
      .WIDTH (VAL_W),
      .DEPTH (WINDOW_LENGTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (scaled_ff),
      .raddr (pos_ff),
      .rdata (oldest)
   );

   assign mean_value = prod_ff[SHIFT +: VAL_W];

   always_comb begin
      sample_in   = cmd.capture ? req_payload.sample_millivolts : sample_ff;
      scaled_in   = scaled_ff;
      sum_in      = sum_ff;
      pos_in      = pos_ff;
      fill_cnt_in = fill_cnt_ff;
      primed_in   = primed_ff;
      prod_in     = prod_ff;
      out_in      = out_ff;
      if (cmd.scale_start && (clamp_low || clamp_high)) begin
         scaled_in = clamp_value;
      end else if (cmd.scale_load_div) begin
         scaled_in = quotient;
      end
      if (cmd.fill_write) begin
         sum_in      = {{PTR_W{1'b0}}, scaled_ff} * SUM_W'(WINDOW_LENGTH);
         fill_cnt_in = fill_last ? '0 : fill_cnt_ff + 1'b1;
         if (fill_last) begin
            pos_in    = PTR_W'(1);
            primed_in = 1'b1;
         end
      end
      if (cmd.update) begin
         sum_in = sum_ff - {{PTR_W{1'b0}}, oldest} + {{PTR_W{1'b0}}, scaled_ff};
         pos_in = (pos_ff == LAST_POS) ? '0 : pos_ff + 1'b1;
      end
      if (cmd.mean) begin
         prod_in = {{RECIP_W{1'b0}}, sum_ff} * {{SUM_W{1'b0}}, RECIP};
      end
      if (cmd.load_out) begin
         out_in.smoothed_value = cmd.out_direct ? scaled_ff : mean_value;
         out_in.scaled_sample  = scaled_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff      <= LOW_MV_RESET;
         high_ff     <= HIGH_MV_RESET;
         fs_ff       <= FULL_SCALE_RESET;
         sum_ff      <= '0;
         pos_ff      <= '0;
         fill_cnt_ff <= '0;
         primed_ff   <= 1'b0;
      end else begin
         low_ff      <= low_in;
         high_ff     <= high_in;
         fs_ff       <= fs_in;
         sum_ff      <= sum_in;
         pos_ff      <= pos_in;
         fill_cnt_ff <= fill_cnt_in;
         primed_ff   <= primed_in;
      end
      sample_ff <= sample_in;
      scaled_ff <= scaled_in;
      prod_ff   <= prod_in;
      out_ff    <= out_in;
   end

   assign rsp_payload      = out_ff;
   assign status.clamp     = clamp_low | clamp_high;
   assign status.div_busy  = div_busy;
   assign status.primed    = primed_ff;
   assign status.fill_last = fill_last;

endmodule

### rtl/core/smav_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smav_ctrl
// Sequencer for one item at a time: capture, scale, ring fill or update then
// mean, and hand-off to the output register.
// ---------------------------------------------------------------------------
module smav_ctrl import smav_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_MULT   = 7'b0000010,
      ST_DIV    = 7'b0000100,
      ST_FILL   = 7'b0001000,
      ST_UPDATE = 7'b0010000,
      ST_MEAN   = 7'b0100000,
      ST_OUT    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      direct_ff, direct_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      direct_in    = direct_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.scale_start = 1'b1;
            if (!status.clamp) begin
               state_in = ST_DIV;
            end else begin
               state_in = status.primed ? ST_UPDATE : ST_FILL;
            end
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               cmd.scale_load_div = 1'b1;
               state_in           = status.primed ? ST_UPDATE : ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill_write = 1'b1;
            direct_in      = 1'b1;
            if (status.fill_last) begin
               state_in = ST_OUT;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            direct_in  = 1'b0;
            state_in   = ST_MEAN;
         end
         ST_MEAN: begin
            cmd.mean = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out   = 1'b1;
               cmd.out_direct = direct_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         direct_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         direct_ff    <= direct_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/core/sensor_scale_and_moving_average_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sensor_scale_and_moving_average_top
// Clamps and rescales a millivolt sample, then smooths it with a boxcar mean.
//
//   channel   dir   handshake       payload
//   req_chan  in    valid / ready   sample_millivolts
//   rsp_chan  out   valid / ready   smoothed_value, scaled_sample
//   csr_*     in    csr_we          csr_index, csr_wdata
//
// One item at a time; the 16-step divider runs only when the sample does not
// clamp, and the first item after reset fills all WINDOW_LENGTH ring entries
// in place of the update and mean steps.
// The next item is taken while a result still waits in the output register.
// Reset is synchronous and restores the register defaults and an empty window.
// ---------------------------------------------------------------------------
`include "sensor_scale_and_moving_average_top_assert.svh"

module sensor_scale_and_moving_average_top import smav_pkg::*; #(
   parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   smav_stream_if.sink           req_chan,
   smav_stream_if.source         rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type         cmd;
   status_type      status;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;

   assign req_payload      = req_chan.payload;
   assign rsp_chan.payload = rsp_payload;

   smav_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   smav_dpath #(
      .WINDOW_LENGTH (WINDOW_LENGTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

   `SMAV_ASSERT_NEXT(a_one_item_in_flight, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   `SMAV_ASSERT_IMPLY(a_no_result_while_dividing, clock, reset, status.div_busy, !cmd.load_out)
   `SMAV_ASSERT_NEXT(a_result_presented, clock, reset, cmd.load_out, rsp_chan.valid)
   `SMAV_ASSERT_HOLDS(a_single_step, clock, reset, $onehot0({cmd.scale_start, cmd.fill_write, cmd.update, cmd.mean, cmd.load_out}))

endmodule

### bench/sensor_scale_and_moving_average_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sensor scale and moving average checker
// Watches the sample, result and register ports, keeps its own copy of the
// clamp/rescale stage and the eight-entry boxcar window, and compares every
// result item field by field against the oldest predicted one.
// ---------------------------------------------------------------------------
module sensor_scale_and_moving_average_checker import smav_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_payload_type       req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_payload_type       rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    pending_items,
   output int                    mismatch_count
);

   localparam int WIN   = WINDOW_LENGTH_DEFAULT;
   localparam int PTR_W = $clog2(WIN);
   localparam int SUM_W = VAL_W + $clog2(WIN);

   logic [MV_W-1:0]  low_mv;
   logic [MV_W-1:0]  high_mv;
   logic [VAL_W-1:0] full_scale;

   logic [VAL_W-1:0] ring [WIN];
   logic [PTR_W-1:0] write_pos;
   logic             primed;
   logic [SUM_W-1:0] window_sum;

   rsp_payload_type  expected_results [$];
   rsp_payload_type  oldest;
   int               samples_in = 0;
   int               results_out = 0;
   int               errors = 0;

   assign pending_items  = samples_in - results_out;
   assign mismatch_count = errors;

   function automatic logic [VAL_W-1:0] scale_mv(input logic [MV_W-1:0] mv);
      logic [NUM_W-1:0] num;
      if (mv <= low_mv) return '0;
      if (mv >= high_mv) return full_scale;
      num = (mv - low_mv) * full_scale;
      return num / (high_mv - low_mv);
   endfunction

   function automatic rsp_payload_type smooth_sample(input logic [MV_W-1:0] mv);
      rsp_payload_type r;
      r.scaled_sample = scale_mv(mv);
      if (!primed) begin
         for (int i = 0; i < WIN; i++) ring[i] = r.scaled_sample;
         window_sum       = SUM_W'(r.scaled_sample) * SUM_W'(WIN);
         write_pos        = PTR_W'(1 % WIN);
         primed           = 1'b1;
         r.smoothed_value = r.scaled_sample;
      end else begin
         window_sum       = window_sum - ring[write_pos] + r.scaled_sample;
         ring[write_pos]  = r.scaled_sample;
         write_pos        = PTR_W'((int'(write_pos) + 1) % WIN);
         r.smoothed_value = VAL_W'(window_sum / WIN);
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input int want, input int got);
      if (errors < 10)
         $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
      errors++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         low_mv      = LOW_MV_RESET;
         high_mv     = HIGH_MV_RESET;
         full_scale  = FULL_SCALE_RESET;
         write_pos   = '0;
         primed      = 1'b0;
         window_sum  = '0;
         expected_results.delete();
         samples_in  <= 0;
         results_out <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(smooth_sample(req_payload.sample_millivolts));
            samples_in <= samples_in + 1;
         end
         if (rsp_valid && rsp_ready) begin
            results_out <= results_out + 1;
            if (expected_results.size() == 0) begin
               flag_mismatch("unexpected result item", 0, 1);
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_payload.smoothed_value !== oldest.smoothed_value)
                  flag_mismatch("smoothed_value", int'(oldest.smoothed_value),
                                int'(rsp_payload.smoothed_value));
               if (rsp_payload.scaled_sample !== oldest.scaled_sample)
                  flag_mismatch("scaled_sample", int'(oldest.scaled_sample),
                                int'(rsp_payload.scaled_sample));
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_LOW_MV:     low_mv     = csr_wdata[MV_W-1:0];
               CSR_HIGH_MV:    high_mv    = csr_wdata[MV_W-1:0];
               CSR_FULL_SCALE: full_scale = csr_wdata[VAL_W-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

### bench/tb_sensor_scale_and_moving_average_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sensor scale and moving average testbench
// Drives millivolt samples through a short directed set and randomized
// register phases, with random gaps on both sides and one long result stall,
// and reports the verdict from the checker's mismatch count.
// ---------------------------------------------------------------------------
module tb_sensor_scale_and_moving_average_top;
   import smav_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int PHASES      = 14;
   localparam int PHASE_ITEMS = 52;
   localparam int HOLD_PHASE  = 3;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   logic req_calm     = 1'b0;
   logic rsp_calm     = 1'b0;
   logic hold_request = 1'b0;
   logic rsp_hold;
   int   rsp_gap;
   int   pending_items;
   int   mismatch_count;
   int   cycle_count = 0;

   smav_stream_if #(.payload_type(req_payload_type)) req_chan ();
   smav_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   sensor_scale_and_moving_average_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sensor_scale_and_moving_average_checker avg_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_payload    (req_chan.payload),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_payload    (rsp_chan.payload),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .pending_items  (pending_items),
      .mismatch_count (mismatch_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side: random stall per item, or a long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b0;
      rsp_gap = 0;
      forever begin
         @(posedge clock);
         if (reset || rsp_hold) begin
            rsp_chan.ready <= 1'b0;
         end else if (rsp_chan.ready) begin
            if (rsp_chan.valid) begin
               rsp_gap = rsp_calm ? 0 : $urandom_range(0, 12);
               if (rsp_gap != 0) begin
                  rsp_chan.ready <= 1'b0;
                  rsp_gap = rsp_gap - 1;
               end
            end
         end else if (rsp_gap != 0) begin
            rsp_gap = rsp_gap - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      rsp_hold <= 1'b0;
      do @(posedge clock); while (!hold_request);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic send_sample(input logic [MV_W-1:0] mv);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid                     <= 1'b1;
      req_chan.payload.sample_millivolts <= mv;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // drain, then write the unused index and all three registers back to back
   task automatic program_settings(input logic [MV_W-1:0] low, input logic [MV_W-1:0] high,
                                   input logic [VAL_W-1:0] fs);
      logic [CSR_IDX_W-1:0]  idx  [4];
      logic [CSR_DATA_W-1:0] data [4];
      idx  = '{CSR_UNUSED, CSR_LOW_MV, CSR_HIGH_MV, CSR_FULL_SCALE};
      data = '{16'($urandom), {4'($urandom), low}, {4'($urandom), high}, fs};
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_items != 0);
      repeat (4) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= data[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [MV_W-1:0] pick_sample(input logic [MV_W-1:0] low,
                                                   input logic [MV_W-1:0] high);
      int v;
      case ($urandom_range(0, 9))
         0:       v = int'(low) + int'($urandom_range(0, 4)) - 2;
         1:       v = int'(high) + int'($urandom_range(0, 4)) - 2;
         2:       v = $urandom_range(0, 1) ? 0 : 4095;
         default: v = $urandom_range(0, 4095);
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return MV_W'(v);
   endfunction

   initial begin
      logic [MV_W-1:0]  low;
      logic [MV_W-1:0]  high;
      logic [VAL_W-1:0] fs;

      reset                     <= 1'b1;
      req_chan.valid            <= 1'b0;
      req_chan.payload          <= '0;
      csr_we                    <= 1'b0;
      csr_index                 <= '0;
      csr_wdata                 <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // register defaults; the first item primes the whole window
      send_sample(12'd1650); send_sample(12'd0);    send_sample(12'd4095);
      send_sample(12'd3300); send_sample(12'd3299); send_sample(12'd1);
      send_sample(12'hAAA);  send_sample(12'h555);

      program_settings(12'd100, 12'd4000, 16'hFFFF);
      send_sample(12'd99);   send_sample(12'd100);  send_sample(12'd101);
      send_sample(12'd3999); send_sample(12'd4000); send_sample(12'd4095);
      send_sample(12'd2050);

      // equal bounds: always clamps
      program_settings(12'd2000, 12'd2000, 16'd1);
      send_sample(12'd1999); send_sample(12'd2000); send_sample(12'd2001);

      // reversed bounds with zero full scale
      program_settings(12'd4095, 12'd0, 16'd0);
      send_sample(12'd0); send_sample(12'd4095); send_sample(12'd2048);

      program_settings(12'd0, 12'd4095, 16'd0);
      send_sample(12'd1); send_sample(12'd4094);

      for (int p = 0; p < PHASES; p++) begin
         case ($urandom_range(0, 5))
            0: begin
               low  = LOW_MV_RESET;
               high = HIGH_MV_RESET;
               fs   = FULL_SCALE_RESET;
            end
            1: begin
               low  = '0;
               high = '1;
               fs   = '1;
            end
            2: begin
               low  = MV_W'($urandom_range(0, 2000));
               high = MV_W'($urandom_range(int'(low) + 2, 4095));
               fs   = VAL_W'($urandom_range(1, 65535));
            end
            3: begin
               high = MV_W'($urandom_range(0, 4095));
               low  = MV_W'($urandom_range(int'(high), 4095));
               fs   = VAL_W'($urandom);
            end
            4: begin
               low  = MV_W'($urandom_range(0, 4000));
               high = MV_W'($urandom_range(int'(low) + 1, 4095));
               case ($urandom_range(0, 2))
                  0:       fs = '0;
                  1:       fs = 16'd1;
                  default: fs = '1;
               endcase
            end
            default: begin
               low  = MV_W'($urandom_range(0, 4090));
               high = low + MV_W'($urandom_range(1, 4));
               fs   = VAL_W'($urandom);
            end
         endcase
         program_settings(low, high, fs);
         req_calm = ($urandom_range(0, 3) == 0);
         if (p == HOLD_PHASE) begin
            req_calm = 1'b1;
            rsp_calm <= 1'b0;
         end else begin
            rsp_calm <= ($urandom_range(0, 3) == 0);
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == HOLD_PHASE && k == 5) hold_request <= 1'b1;
            send_sample(pick_sample(low, high));
         end
      end

      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_items != 0);
      repeat (30) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
